/* design/matrix_inverse_3x3_core_macros.svh */
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core_macros
// Assertion helpers for the checker file.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_CORE_MACROS_SVH
`define MATRIX_INVERSE_3X3_CORE_MACROS_SVH

// clocked on clk_i, off while rst_ni is low
`define MI3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked on clk_i, also checked during reset
`define MI3_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/mi3_pkg.sv */
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants for the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEM_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_ELEM       = 9;
  localparam int THRESH_W       = 32;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd4295;

endpackage

/* design/mi3_front.sv */
// ----------------------------------------------------------------------------
// mi3_front
// Cofactors, determinant and singular test; six pipeline stages.
// ----------------------------------------------------------------------------
module mi3_front #(
  parameter int EW = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int FW = mi3_pkg::FRAC_BITS_DEF,
  parameter int QW = 9 * (2 * EW + 1) + (3 * EW + 1) + 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mi3_pkg::THRESH_W-1:0]  thresh_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mi3_pkg::NUM_ELEM*EW-1:0] in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [QW-1:0]                 out_data_o
);
  import mi3_pkg::*;

  localparam int PW   = 2 * EW;
  localparam int CW   = 2 * EW + 1;
  localparam int DW   = 3 * EW + 1;
  localparam int CMPW = DW + THRESH_W + 3 * FW;
  localparam int NS   = 6;
  localparam int MIDX [NUM_ELEM][4] = '{
    '{4, 8, 5, 7}, '{3, 8, 5, 6}, '{3, 7, 4, 6},
    '{1, 8, 2, 7}, '{0, 8, 2, 6}, '{0, 7, 1, 6},
    '{1, 5, 2, 4}, '{0, 5, 2, 3}, '{0, 4, 1, 3}
  };
  localparam logic [NUM_ELEM-1:0] COF_NEG = 9'b010101010;

  logic [NS:0]   en;
  logic [NS-1:0] v_q;

  logic signed [EW-1:0]   a_q  [NUM_ELEM];
  logic signed [EW-1:0]   a1_q [3];
  logic signed [EW-1:0]   a2_q [3];
  logic signed [PW-1:0]   pa_q [NUM_ELEM];
  logic signed [PW-1:0]   pb_q [NUM_ELEM];
  logic signed [CW-1:0]   c2_q [NUM_ELEM];
  logic signed [CW-1:0]   c3_q [NUM_ELEM];
  logic signed [CW-1:0]   c4_q [NUM_ELEM];
  logic signed [CW-1:0]   c5_q [NUM_ELEM];
  logic signed [PW+1:0]   pl_q [3];
  logic signed [PW-1:0]   ph_q [3];
  logic signed [DW-1:0]   det_d, det_q;
  logic [DW-1:0]          dmag_d, dmag_q;
  logic                   dneg_q, sing_d, sing_q;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_comb begin
    det_d = '0;
    for (int i = 0; i < 3; i++) begin
      det_d = det_d + (DW'(ph_q[i]) <<< (EW + 1)) + DW'(pl_q[i]);
    end
    dmag_d = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    sing_d = (CMPW'(thresh_i) << (3 * FW)) >= (CMPW'(dmag_d) << THRESH_W);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < NUM_ELEM; i++) a_q[i] <= in_data_i[i*EW +: EW];
    end
    if (en[1]) begin
      for (int j = 0; j < NUM_ELEM; j++) begin
        pa_q[j] <= a_q[MIDX[j][0]] * a_q[MIDX[j][1]];
        pb_q[j] <= a_q[MIDX[j][2]] * a_q[MIDX[j][3]];
      end
      for (int i = 0; i < 3; i++) a1_q[i] <= a_q[i];
    end
    if (en[2]) begin
      for (int j = 0; j < NUM_ELEM; j++) begin
        c2_q[j] <= COF_NEG[j] ? (CW'(pb_q[j]) - CW'(pa_q[j]))
                              : (CW'(pa_q[j]) - CW'(pb_q[j]));
      end
      for (int i = 0; i < 3; i++) a2_q[i] <= a1_q[i];
    end
    if (en[3]) begin
      // cofactor split: signed high part and unsigned low EW+1 bits
      for (int i = 0; i < 3; i++) begin
        pl_q[i] <= a2_q[i] * $signed({1'b0, c2_q[i][EW:0]});
        ph_q[i] <= a2_q[i] * $signed(c2_q[i][CW-1:EW+1]);
      end
      c3_q <= c2_q;
    end
    if (en[4]) begin
      det_q <= det_d;
      c4_q  <= c3_q;
    end
    if (en[5]) begin
      c5_q   <= c4_q;
      dmag_q <= dmag_d;
      dneg_q <= det_q[DW-1];
      sing_q <= sing_d;
    end
  end

  always_comb begin
    out_data_o = '0;
    for (int j = 0; j < NUM_ELEM; j++) out_data_o[j*CW +: CW] = c5_q[j];
    out_data_o[NUM_ELEM*CW +: DW]   = dmag_q;
    out_data_o[NUM_ELEM*CW + DW]     = dneg_q;
    out_data_o[NUM_ELEM*CW + DW + 1] = sing_q;
  end

endmodule

/* design/mi3_queue.sv */
// ----------------------------------------------------------------------------
// mi3_queue
// Two-entry request queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module mi3_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);
  import mi3_pkg::*;

  logic [W-1:0] ent_q [2];
  logic [1:0]   cnt_q;
  logic         wr_q, rd_q;
  logic         push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = ent_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= in_data_i;
  end

endmodule

/* design/mi3_back.sv */
// ----------------------------------------------------------------------------
// mi3_back
// Nine-lane restoring divider, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module mi3_back #(
  parameter int EW = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int FW = mi3_pkg::FRAC_BITS_DEF,
  parameter int QW = 9 * (2 * EW + 1) + (3 * EW + 1) + 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [QW-1:0]                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mi3_pkg::NUM_ELEM*EW-1:0] out_data_o,
  output logic [1:0]                      out_user_o
);
  import mi3_pkg::*;

  localparam int CW  = 2 * EW + 1;
  localparam int DW  = 3 * EW + 1;
  localparam int NW  = 2 * EW + 2 * FW;
  localparam int SW  = DW + EW;
  localparam int RW  = ((NW > SW) ? NW : SW) + 1;
  localparam int NB  = EW + 2;
  localparam logic [EW-1:0] POS_MAX = {1'b0, {(EW-1){1'b1}}};

  logic [NB:0]   en;
  logic [NB-1:0] v_q;

  logic [RW-1:0] rem_q  [EW][NUM_ELEM];
  logic [EW-1:0] quo_q  [EW+1][NUM_ELEM];
  logic          neg_q  [EW+1][NUM_ELEM];
  logic          ovr_q  [EW+1][NUM_ELEM];
  logic [DW-1:0] dmag_q [EW];
  logic          sing_q [EW+1];
  logic [EW-1:0] res_q  [NUM_ELEM];
  logic          sat_q, sgo_q;

  logic signed [CW-1:0] cin    [NUM_ELEM];
  logic [CW-1:0]        cmag   [NUM_ELEM];
  logic [RW-1:0]        n0     [NUM_ELEM];
  logic                 ovr0   [NUM_ELEM];
  logic                 neg0   [NUM_ELEM];
  logic [DW-1:0]        dmag_in;
  logic                 dneg_in, sing_in;
  logic [RW-1:0]        dsh_c  [1:EW];
  logic                 ge_c   [1:EW][NUM_ELEM];
  logic [EW-1:0]        lim_c  [NUM_ELEM];
  logic [EW-1:0]        mag_c  [NUM_ELEM];
  logic [EW-1:0]        res_c  [NUM_ELEM];
  logic                 clip_c [NUM_ELEM];
  logic                 sat_c;

  always_comb begin
    en[NB] = out_ready_i;
    for (int k = NB - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NB-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NB; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // operand setup: |adj| << 2F and the quotient overflow check
  always_comb begin
    dmag_in = in_data_i[NUM_ELEM*CW +: DW];
    dneg_in = in_data_i[NUM_ELEM*CW + DW];
    sing_in = in_data_i[NUM_ELEM*CW + DW + 1];
    for (int j = 0; j < NUM_ELEM; j++) begin
      cin[j]  = $signed(in_data_i[j*CW +: CW]);
      cmag[j] = cin[j][CW-1] ? CW'(-cin[j]) : CW'(cin[j]);
      n0[j]   = RW'(cmag[j]) << (2 * FW);
      ovr0[j] = n0[j] >= (RW'(dmag_in) << EW);
      neg0[j] = cin[j][CW-1] ^ dneg_in;
    end
  end

  always_comb begin
    for (int k = 1; k <= EW; k++) begin
      dsh_c[k] = RW'(dmag_q[k-1]) << (EW - k);
      for (int j = 0; j < NUM_ELEM; j++) begin
        ge_c[k][j] = rem_q[k-1][j] >= dsh_c[k];
      end
    end
  end

  always_comb begin
    sat_c = 1'b0;
    for (int j = 0; j < NUM_ELEM; j++) begin
      lim_c[j]  = neg_q[EW][j] ? (POS_MAX + EW'(1)) : POS_MAX;
      clip_c[j] = ovr_q[EW][j] || (quo_q[EW][j] > lim_c[j]);
      mag_c[j]  = clip_c[j] ? lim_c[j] : quo_q[EW][j];
      res_c[j]  = sing_q[EW] ? '0 : (neg_q[EW][j] ? EW'(-mag_c[j]) : mag_c[j]);
      sat_c     = sat_c | clip_c[j];
    end
    sat_c = sat_c && !sing_q[EW];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int j = 0; j < NUM_ELEM; j++) begin
        rem_q[0][j] <= n0[j];
        quo_q[0][j] <= '0;
        neg_q[0][j] <= neg0[j];
        ovr_q[0][j] <= ovr0[j];
      end
      dmag_q[0] <= dmag_in;
      sing_q[0] <= sing_in;
    end
    for (int k = 1; k < EW; k++) begin
      if (en[k]) begin
        for (int j = 0; j < NUM_ELEM; j++) begin
          rem_q[k][j] <= ge_c[k][j] ? (rem_q[k-1][j] - dsh_c[k]) : rem_q[k-1][j];
        end
        dmag_q[k] <= dmag_q[k-1];
      end
    end
    for (int k = 1; k <= EW; k++) begin
      if (en[k]) begin
        for (int j = 0; j < NUM_ELEM; j++) begin
          quo_q[k][j] <= quo_q[k-1][j] | (EW'(ge_c[k][j]) << (EW - k));
          neg_q[k][j] <= neg_q[k-1][j];
          ovr_q[k][j] <= ovr_q[k-1][j];
        end
        sing_q[k] <= sing_q[k-1];
      end
    end
    if (en[NB-1]) begin
      res_q <= res_c;
      sat_q <= sat_c;
      sgo_q <= sing_q[EW];
    end
  end

  // inverse element (i, j) comes from cofactor (j, i)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        out_data_o[(i*3+j)*EW +: EW] = res_q[j*3+i];
      end
    end
  end
  assign out_user_o = {sat_q, sgo_q};

endmodule

/* design/matrix_inverse_3x3_core.sv */
// Throughput: one matrix per cycle while the output is not stalled;
// the divider resolves one quotient bit per stage.
// A stalled output backs up through the queue and both pipelines in turn.
// Reset: asynchronous, active low; clears valids, threshold returns to 4295.
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core
// 3x3 fixed-point matrix inverse by adjugate over determinant.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_core #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mi3_pkg::THRESH_W-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // m00 m01 m02 m10 m11 m12 m20 m21 m22, byte padded
  input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // r00 r01 r02 r10 r11 r12 r20 r21 r22, byte padded
  output logic [((9*ELEM_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // singular, saturated
  output logic [1:0]                    m_axis_tuser
);
  import mi3_pkg::*;

  localparam int EW      = ELEM_WIDTH;
  localparam int TDATA_W = ((NUM_ELEM * EW + 7) / 8) * 8;
  localparam int QW      = NUM_ELEM * (2 * EW + 1) + (3 * EW + 1) + 2;

  logic [THRESH_W-1:0] thresh_q;
  logic                fq_valid, fq_ready, qb_valid, qb_ready;
  logic [QW-1:0]       fq_data, qb_data;
  logic [NUM_ELEM*EW-1:0] res_flat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  mi3_front #(.EW(EW), .FW(FRAC_BITS), .QW(QW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .thresh_i   (thresh_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata[NUM_ELEM*EW-1:0]),
    .out_valid_o(fq_valid),
    .out_ready_i(fq_ready),
    .out_data_o (fq_data)
  );

  mi3_queue #(.W(QW)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fq_valid),
    .in_ready_o (fq_ready),
    .in_data_i  (fq_data),
    .out_valid_o(qb_valid),
    .out_ready_i(qb_ready),
    .out_data_o (qb_data)
  );

  mi3_back #(.EW(EW), .FW(FRAC_BITS), .QW(QW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (qb_valid),
    .in_ready_o (qb_ready),
    .in_data_i  (qb_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (res_flat),
    .out_user_o (m_axis_tuser)
  );

  assign m_axis_tdata = TDATA_W'(res_flat);

endmodule

/* design/mi3_checker.sv */
// ----------------------------------------------------------------------------
// mi3_checker
// Port-level checks for the matrix inverse core.
// ----------------------------------------------------------------------------
`include "matrix_inverse_3x3_core_macros.svh"

module mi3_checker #(
  parameter int TDATA_W = 216
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]         m_axis_tuser
);
  import mi3_pkg::*;

  logic [7:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 8'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 8'd1;
    end
  end

  `MI3_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `MI3_ASSERT(a_singular_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1], "singular result not cleared")
  `MI3_ASSERT(a_no_spurious, pend_q == 8'd0 |-> !m_axis_tvalid, "result without pending request")
  `MI3_ASSERT_RST(a_reset_idle, !rst_ni |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind matrix_inverse_3x3_core mi3_checker #(.TDATA_W(TDATA_W)) u_mi3_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

/* test/tb_matrix_inverse_3x3_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_inverse_3x3_core
// Streams 3x3 Q8.16 matrices into the inverse core under bursty input and
// random output stalls, and compares every result with a fixed value or a
// 128-bit exact adjugate/det predictor, at several singular thresholds.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_3x3_core;
  import mi3_pkg::*;

  localparam int EW     = ELEM_WIDTH_DEF;
  localparam int FB     = FRAC_BITS_DEF;
  localparam int DW     = ((9 * EW + 7) / 8) * 8;
  localparam int LAT    = EW + 8;
  localparam int N_RAND = 125;
  localparam int MX     = (1 << (EW - 1)) - 1;
  localparam int MN     = -(1 << (EW - 1));
  localparam int ONE    = 1 << FB;

  typedef logic signed [127:0] wide_t;
  typedef enum logic [1:0] {EXP_PRED, EXP_SINGULAR, EXP_IDENTITY} exp_kind_e;

  typedef struct {
    logic [DW-1:0] data;
    logic [1:0]    user;
  } inv_res_t;

  typedef struct {
    logic [DW-1:0] mat;
    exp_kind_e     kind;
  } vec_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [THRESH_W-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DW-1:0]     s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DW-1:0]     m_axis_tdata;
  logic [1:0]        m_axis_tuser;

  logic [THRESH_W-1:0] thresh_q = THRESH_RESET;
  inv_res_t          inverse_q[$];
  vec_t              dir_tbl[$];
  int                errors = 0;
  int                rx_mode = 0;
  int                rx_cnt = 0;

  matrix_inverse_3x3_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [DW-1:0] mk(int e0, int e1, int e2, int e3, int e4,
                                       int e5, int e6, int e7, int e8);
    int e[9];
    logic [DW-1:0] d;
    e = '{e0, e1, e2, e3, e4, e5, e6, e7, e8};
    d = '0;
    for (int i = 0; i < 9; i++) d[i*EW +: EW] = e[i][EW-1:0];
    return d;
  endfunction

  function automatic wide_t minor2(longint a, longint b, longint c, longint d);
    return wide_t'(a) * wide_t'(b) - wide_t'(c) * wide_t'(d);
  endfunction

  function automatic inv_res_t invert(logic [DW-1:0] mat, logic [THRESH_W-1:0] thr);
    longint   e[9];
    wide_t    c[9];
    wide_t    det, dmag, adj, q, lim, mag, thr_w;
    logic     neg, sat;
    inv_res_t r;
    logic signed [EW-1:0] el;
    for (int i = 0; i < 9; i++) begin
      el = mat[i*EW +: EW];
      e[i] = el;
    end
    c[0] = minor2(e[4], e[8], e[5], e[7]);
    c[1] = -minor2(e[3], e[8], e[5], e[6]);
    c[2] = minor2(e[3], e[7], e[4], e[6]);
    c[3] = -minor2(e[1], e[8], e[2], e[7]);
    c[4] = minor2(e[0], e[8], e[2], e[6]);
    c[5] = -minor2(e[0], e[7], e[1], e[6]);
    c[6] = minor2(e[1], e[5], e[2], e[4]);
    c[7] = -minor2(e[0], e[5], e[2], e[3]);
    c[8] = minor2(e[0], e[4], e[1], e[3]);
    det = c[0] * wide_t'(e[0]) + c[1] * wide_t'(e[1]) + c[2] * wide_t'(e[2]);
    dmag = (det < 0) ? -det : det;
    thr_w = $signed({96'd0, thr}) <<< (3 * FB - 32);
    r.data = '0;
    r.user = 2'b01;
    if (thr_w >= dmag) return r;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        adj = c[j*3+i];
        neg = (adj < 0) != (det < 0);
        q = (((adj < 0) ? -adj : adj) <<< (2 * FB)) / dmag;
        lim = neg ? (wide_t'(1) <<< (EW - 1)) : (wide_t'(1) <<< (EW - 1)) - 1;
        if (q > lim) begin
          mag = lim;
          sat = 1'b1;
        end else begin
          mag = q;
        end
        mag = neg ? -mag : mag;
        r.data[(i*3+j)*EW +: EW] = mag[EW-1:0];
      end
    end
    r.user = {sat, 1'b0};
    return r;
  endfunction

  function automatic int rnd_s(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [DW-1:0] rnd_matrix();
    int e[9];
    logic [DW-1:0] d;
    case ($urandom_range(0, 3))
      0: for (int i = 0; i < 9; i++) e[i] = int'($urandom());
      1: for (int i = 0; i < 9; i++) e[i] = rnd_s(1 << 17);
      2: for (int i = 0; i < 9; i++) begin
        e[i] = (i % 4 == 0) ? rnd_s(1 << 20) : rnd_s(1 << 14);
      end
      default: begin
        for (int i = 0; i < 6; i++) e[i] = rnd_s(1 << 18);
        for (int i = 6; i < 9; i++) e[i] = e[i-6] + rnd_s($urandom_range(0, 3));
      end
    endcase
    d = '0;
    for (int i = 0; i < 9; i++) d[i*EW +: EW] = e[i][EW-1:0];
    return d;
  endfunction

  task automatic send(logic [DW-1:0] mat, exp_kind_e kind);
    inv_res_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= mat;
    do @(posedge clk_i); while (!s_axis_tready);
    case (kind)
      EXP_SINGULAR: begin
        r.data = '0;
        r.user = 2'b01;
      end
      EXP_IDENTITY: begin
        r.data = mk(1 << FB, 0, 0, 0, 1 << FB, 0, 0, 0, 1 << FB);
        r.user = 2'b00;
      end
      default: r = invert(mat, thresh_q);
    endcase
    inverse_q.push_back(r);
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (inverse_q.size() == 0);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_thresh(logic [THRESH_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    thresh_q = v;
  endtask

  task automatic random_phase(int n);
    int left;
    left = n;
    while (left > 0) begin
      for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--) begin
        send(rnd_matrix(), EXP_PRED);
        left--;
      end
      gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      if (left == n / 2) begin
        s_axis_tvalid <= 1'b0;
        wait (inverse_q.size() == 0);
      end
    end
  endtask

  // output side: result checks and a randomly changing stall mode
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (inverse_q.size() == 0) begin
        $display("%0t unexpected result data=%h user=%b", $time, m_axis_tdata,
                 m_axis_tuser);
        errors++;
      end else begin
        for (int k = 0; k < 9; k++) begin
          if (m_axis_tdata[k*EW +: EW] !== inverse_q[0].data[k*EW +: EW]) begin
            $display("%0t r%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                     inverse_q[0].data[k*EW +: EW], m_axis_tdata[k*EW +: EW]);
            errors++;
          end
        end
        if (m_axis_tuser[0] !== inverse_q[0].user[0]) begin
          $display("%0t singular expected %b actual %b", $time,
                   inverse_q[0].user[0], m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== inverse_q[0].user[1]) begin
          $display("%0t saturated expected %b actual %b", $time,
                   inverse_q[0].user[1], m_axis_tuser[1]);
          errors++;
        end
        void'(inverse_q.pop_front());
      end
    end
    rx_cnt <= rx_cnt + 1;
    if (rx_cnt % 64 == 0) rx_mode <= $urandom_range(0, 2);
    if (!rst_ni) m_axis_tready <= 1'b0;
    else case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      default: m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  initial begin
    dir_tbl.push_back('{mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), EXP_IDENTITY});
    dir_tbl.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), EXP_SINGULAR});
    dir_tbl.push_back('{mk(MX, MX, MX, MX, MX, MX, MX, MX, MX), EXP_SINGULAR});
    dir_tbl.push_back('{mk(MN, MN, MN, MN, MN, MN, MN, MN, MN), EXP_SINGULAR});
    dir_tbl.push_back('{mk(1, 0, 0, 0, 1, 0, 0, 0, 1), EXP_SINGULAR});
    dir_tbl.push_back('{mk(ONE, 2, 3, ONE, 2, 3, 7, 8, 9), EXP_SINGULAR});
    dir_tbl.push_back('{mk(MX, 0, 0, 0, MX, 0, 0, 0, MX), EXP_PRED});
    dir_tbl.push_back('{mk(MN, 0, 0, 0, MN, 0, 0, 0, MN), EXP_PRED});
    dir_tbl.push_back('{mk(MN, 0, 0, 0, ONE, 0, 0, 0, ONE), EXP_PRED});
    dir_tbl.push_back('{mk(ONE, 0, 0, 0, ONE, 0, 0, 0, 256), EXP_PRED});
    dir_tbl.push_back('{mk(-ONE, 0, 0, 0, ONE, 0, 0, 0, -256), EXP_PRED});
    dir_tbl.push_back('{mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), EXP_PRED});
    dir_tbl.push_back('{mk(0, ONE, 0, 0, 0, ONE, ONE, 0, 0), EXP_PRED});
    dir_tbl.push_back('{mk(MX, MN, MX, MN, MX, MN, MX, MX, MN), EXP_PRED});
    dir_tbl.push_back('{mk(MX, MN, 0, 1, MX, MN, MN, 1, MX), EXP_PRED});
    dir_tbl.push_back('{mk(ONE, 3, 0, 0, 256, 0, 0, 0, 4), EXP_PRED});
    dir_tbl.push_back('{mk(ONE, 3, 0, 0, 256, 0, 0, 0, 5), EXP_PRED});
    dir_tbl.push_back('{mk(2, 0, 0, 0, ONE, 0, 0, 0, 1 << 20), EXP_PRED});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tbl[k]) begin
      send(dir_tbl[k].mat, dir_tbl[k].kind);
      if (k % 5 == 4) gap($urandom_range(1, 4));
    end
    drain();

    write_thresh('0);
    send(mk(1, 0, 0, 0, 1, 0, 0, 0, 1), EXP_PRED);
    send(mk(ONE, 2, 3, ONE, 2, 3, 7, 8, 9), EXP_SINGULAR);
    random_phase(N_RAND);
    drain();

    write_thresh('1);
    send(mk(MX, 0, 0, 0, MX, 0, 0, 0, MX), EXP_PRED);
    random_phase(N_RAND);
    drain();

    write_thresh($urandom());
    random_phase(N_RAND);
    drain();

    write_thresh(THRESH_RESET);
    random_phase(N_RAND);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/mi3_pkg.sv
design/mi3_front.sv
design/mi3_queue.sv
design/mi3_back.sv
design/matrix_inverse_3x3_core.sv
design/mi3_checker.sv
test/tb_matrix_inverse_3x3_core.sv
